[hw/rtl/obb_sat_pkg.sv]
// shared constants for the oriented-box separating-axis test
// no dependencies; imported by every module of the block
`default_nettype none
package obb_sat_pkg;
    // spatial dimensions, also the number of axes per box
    localparam int NAX = 3;
    // port widths of the packed fields
    localparam int CENTER_W = 60;
    localparam int HALF_W   = 48;
    localparam int AXIS_W   = 48;
    // number of separating axes tested
    localparam int NTEST    = 15;
endpackage
`default_nettype wire

[hw/rtl/obb_sat_rot.sv]
// rotation matrix and center offset in box A's frame, two register stages
// depends on obb_sat_pkg
`default_nettype none
module obb_sat_rot #(
    parameter int AXIS_FRAC_BITS = 14,
    parameter int POS_WIDTH      = 20,
    parameter int HALF_WIDTH     = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire logic signed [POS_WIDTH-1:0]      i_pa [obb_sat_pkg::NAX],
    input  wire logic signed [POS_WIDTH-1:0]      i_pb [obb_sat_pkg::NAX],
    input  wire logic        [HALF_WIDTH-1:0]     i_ha [obb_sat_pkg::NAX],
    input  wire logic        [HALF_WIDTH-1:0]     i_hb [obb_sat_pkg::NAX],
    input  wire logic signed [AXIS_FRAC_BITS+1:0] i_ax [obb_sat_pkg::NAX][obb_sat_pkg::NAX],
    input  wire logic signed [AXIS_FRAC_BITS+1:0] i_bx [obb_sat_pkg::NAX][obb_sat_pkg::NAX],
    output logic o_valid,
    output logic signed [2*AXIS_FRAC_BITS+5:0]         o_r  [obb_sat_pkg::NAX][obb_sat_pkg::NAX],
    output logic        [2*AXIS_FRAC_BITS+4:0]         o_ar [obb_sat_pkg::NAX][obb_sat_pkg::NAX],
    output logic signed [POS_WIDTH+AXIS_FRAC_BITS+4:0] o_t  [obb_sat_pkg::NAX],
    output logic        [HALF_WIDTH-1:0]               o_ha [obb_sat_pkg::NAX],
    output logic        [HALF_WIDTH-1:0]               o_hb [obb_sat_pkg::NAX]
);
    import obb_sat_pkg::*;

    localparam int AXW = AXIS_FRAC_BITS + 2;
    localparam int PDW = 2 * AXW;
    localparam int RW  = PDW + 2;
    localparam int ARW = RW - 1;
    localparam int DW  = POS_WIDTH + 1;
    localparam int TPW = DW + AXW;
    localparam int TW  = TPW + 2;

    logic                    r_v1;
    logic signed [PDW-1:0]   r_pr [NAX][NAX][NAX];
    logic signed [TPW-1:0]   r_pt [NAX][NAX];
    logic [HALF_WIDTH-1:0]   r_ha1 [NAX];
    logic [HALF_WIDTH-1:0]   r_hb1 [NAX];
    logic signed [DW-1:0]    d [NAX];
    logic signed [RW-1:0]    n_r [NAX][NAX];
    logic signed [RW-1:0]    r_abs [NAX][NAX];
    logic signed [TW-1:0]    n_t [NAX];

    // center difference
    always_comb begin
        for (int k = 0; k < NAX; k++) begin
            d[k] = DW'(i_pb[k]) - DW'(i_pa[k]);
        end
    end

    // stage 1: element products
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NAX; i++) begin
                for (int j = 0; j < NAX; j++) begin
                    for (int k = 0; k < NAX; k++) begin
                        r_pr[i][j][k] <= PDW'(i_ax[i][k] * i_bx[j][k]);
                    end
                end
                for (int k = 0; k < NAX; k++) begin
                    r_pt[i][k] <= TPW'(d[k] * TPW'(i_ax[i][k]));
                end
                r_ha1[i] <= i_ha[i];
                r_hb1[i] <= i_hb[i];
            end
        end
    end

    // dot-product sums and tolerant magnitudes
    always_comb begin
        for (int i = 0; i < NAX; i++) begin
            for (int j = 0; j < NAX; j++) begin
                n_r[i][j] = RW'(r_pr[i][j][0]) + RW'(r_pr[i][j][1]) + RW'(r_pr[i][j][2]);
                r_abs[i][j] = n_r[i][j][RW-1] ? -n_r[i][j] : n_r[i][j];
            end
            n_t[i] = TW'(r_pt[i][0]) + TW'(r_pt[i][1]) + TW'(r_pt[i][2]);
        end
    end

    // stage 2: rotation matrix, |R| plus one lsb, offset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NAX; i++) begin
                for (int j = 0; j < NAX; j++) begin
                    o_r[i][j]  <= n_r[i][j];
                    o_ar[i][j] <= ARW'(r_abs[i][j] + RW'(1));
                end
                o_t[i]  <= n_t[i];
                o_ha[i] <= r_ha1[i];
                o_hb[i] <= r_hb1[i];
            end
        end
    end
endmodule
`default_nettype wire

[hw/rtl/obb_sat_proj.sv]
// projections and radii of the fifteen test axes, two register stages
// depends on obb_sat_pkg
`default_nettype none
module obb_sat_proj #(
    parameter int AXIS_FRAC_BITS = 14,
    parameter int POS_WIDTH      = 20,
    parameter int HALF_WIDTH     = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire logic signed [2*AXIS_FRAC_BITS+5:0]         i_r  [obb_sat_pkg::NAX][obb_sat_pkg::NAX],
    input  wire logic        [2*AXIS_FRAC_BITS+4:0]         i_ar [obb_sat_pkg::NAX][obb_sat_pkg::NAX],
    input  wire logic signed [POS_WIDTH+AXIS_FRAC_BITS+4:0] i_t  [obb_sat_pkg::NAX],
    input  wire logic        [HALF_WIDTH-1:0]               i_ha [obb_sat_pkg::NAX],
    input  wire logic        [HALF_WIDTH-1:0]               i_hb [obb_sat_pkg::NAX],
    output logic o_valid,
    output logic signed [POS_WIDTH+4*AXIS_FRAC_BITS+14:0] o_proj [obb_sat_pkg::NTEST],
    output logic signed [POS_WIDTH+4*AXIS_FRAC_BITS+14:0] o_rhs  [obb_sat_pkg::NTEST]
);
    import obb_sat_pkg::*;

    localparam int F   = AXIS_FRAC_BITS;
    localparam int AXW = F + 2;
    localparam int RW  = 2 * AXW + 2;
    localparam int ARW = RW - 1;
    localparam int TW  = POS_WIDTH + 1 + AXW + 2;
    localparam int LOW = RW / 2;
    localparam int HIW = RW - LOW;
    localparam int HPW = HALF_WIDTH + ARW;
    localparam int THW = TW + HIW;
    localparam int TLW = TW + LOW + 1;
    localparam int CW  = TW + RW + F + 4;

    logic                   r_v3;
    logic [HPW-1:0]         r_p1 [NAX][NAX][NAX];
    logic [HPW-1:0]         r_p2 [NAX][NAX][NAX];
    logic signed [THW-1:0]  r_th [NAX][NAX][NAX];
    logic signed [TLW-1:0]  r_tl [NAX][NAX][NAX];
    logic signed [TW-1:0]   r_t3  [NAX];
    logic [HALF_WIDTH-1:0]  r_ha3 [NAX];
    logic [HALF_WIDTH-1:0]  r_hb3 [NAX];
    logic signed [CW-1:0]   tr [NAX][NAX][NAX];
    logic signed [CW-1:0]   n_proj [NTEST];
    logic signed [CW-1:0]   n_rhs  [NTEST];

    // stage 3: half-length by |R| products, offset by R split in two halves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v3 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < NAX; a++) begin
                for (int b = 0; b < NAX; b++) begin
                    for (int j = 0; j < NAX; j++) begin
                        r_p1[a][b][j] <= HPW'(i_ha[a]) * HPW'(i_ar[b][j]);
                        r_p2[a][b][j] <= HPW'(i_hb[a]) * HPW'(i_ar[b][j]);
                        r_th[a][b][j] <= THW'(i_t[a] * THW'($signed(i_r[b][j][RW-1:LOW])));
                        r_tl[a][b][j] <= TLW'(i_t[a] * TLW'($signed({1'b0, i_r[b][j][LOW-1:0]})));
                    end
                end
                r_t3[a]  <= i_t[a];
                r_ha3[a] <= i_ha[a];
                r_hb3[a] <= i_hb[a];
            end
        end
    end

    // recombine t[a] * R[b][j]
    always_comb begin
        for (int a = 0; a < NAX; a++) begin
            for (int b = 0; b < NAX; b++) begin
                for (int j = 0; j < NAX; j++) begin
                    tr[a][b][j] = (CW'(r_th[a][b][j]) <<< LOW) + CW'(r_tl[a][b][j]);
                end
            end
        end
    end

    // face axes of A and of B
    for (genvar i = 0; i < NAX; i++) begin : g_face
        always_comb begin
            n_proj[i] = CW'(r_t3[i]) <<< F;
            n_rhs[i]  = (CW'(r_ha3[i]) << (2 * F)) + CW'(r_p2[0][i][0])
                      + CW'(r_p2[1][i][1]) + CW'(r_p2[2][i][2]);
            n_proj[NAX+i] = tr[0][0][i] + tr[1][1][i] + tr[2][2][i];
            n_rhs[NAX+i]  = ((CW'(r_p1[0][0][i]) + CW'(r_p1[1][1][i])
                            + CW'(r_p1[2][2][i])) << F) + (CW'(r_hb3[i]) << (3 * F));
        end
    end

    // cross axes A_i x B_j
    for (genvar i = 0; i < NAX; i++) begin : g_ci
        localparam int I1 = (i + 1) % NAX;
        localparam int I2 = (i + 2) % NAX;
        for (genvar j = 0; j < NAX; j++) begin : g_cj
            localparam int J1 = (j + 1) % NAX;
            localparam int J2 = (j + 2) % NAX;
            localparam int N  = 2 * NAX + i * NAX + j;
            always_comb begin
                n_proj[N] = tr[I2][I1][j] - tr[I1][I2][j];
                n_rhs[N]  = (CW'(r_p1[I1][I2][j]) + CW'(r_p1[I2][I1][j])
                           + CW'(r_p2[J1][i][J2]) + CW'(r_p2[J2][i][J1])) << F;
            end
        end
    end

    // stage 4: projection and radius sum per axis
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int n = 0; n < NTEST; n++) begin
                o_proj[n] <= n_proj[n];
                o_rhs[n]  <= n_rhs[n];
            end
        end
    end
endmodule
`default_nettype wire

[hw/rtl/obb_sat_cmp.sv]
// magnitude, compare and reduce of the fifteen axis tests, two register stages
// depends on obb_sat_pkg
`default_nettype none
module obb_sat_cmp #(
    parameter int CW = 91
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  wire logic i_valid,
    input  wire logic signed [CW-1:0] i_proj [obb_sat_pkg::NTEST],
    input  wire logic signed [CW-1:0] i_rhs  [obb_sat_pkg::NTEST],
    output logic o_valid,
    output logic o_overlap
);
    import obb_sat_pkg::*;

    logic                 r_v5;
    logic signed [CW-1:0] r_mag [NTEST];
    logic signed [CW-1:0] r_rhs [NTEST];
    logic [NTEST-1:0]     sep;

    // stage 5: absolute projection
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v5 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int n = 0; n < NTEST; n++) begin
                r_mag[n] <= i_proj[n][CW-1] ? -i_proj[n] : i_proj[n];
                r_rhs[n] <= i_rhs[n];
            end
        end
    end

    // separating when projection strictly exceeds radii
    always_comb begin
        for (int n = 0; n < NTEST; n++) begin
            sep[n] = r_mag[n] > r_rhs[n];
        end
    end

    // stage 6: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_overlap <= ~(|sep);
        end
    end
endmodule
`default_nettype wire

[hw/rtl/obb_separating_axis_test.sv]
// top level of the oriented-box overlap test
// depends on obb_sat_pkg, obb_sat_rot, obb_sat_proj, obb_sat_cmp
//
// usage:
//   input channel i_valid / o_ready carries one box pair per transaction:
//   centers, half-lengths and three axes of each box, packed x,y,z from bit 0.
//   output channel o_valid / i_ready carries one flag o_overlap per pair,
//   1 when no separating axis exists, 0 when the boxes are separated.
// path: each input transaction reaches o_valid through six register
//   stages (products, dot sums, radius products, axis sums, magnitude,
//   compare and reduce).
// throughput: one pair per cycle while the output is not stalled; every stage holds one pair.
// stalls: the whole pipeline advances together; when o_valid is high and
//   i_ready low every stage holds and o_ready drops. with the output empty
//   o_ready stays high.
// reset: synchronous active-low i_rst_n clears all stage valid bits; no
//   result is pending afterward.
`default_nettype none
module obb_separating_axis_test #(
    parameter int AXIS_FRAC_BITS = 14,
    parameter int POS_WIDTH      = 20,
    parameter int HALF_WIDTH     = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire logic [obb_sat_pkg::CENTER_W-1:0] i_a_center,
    input  wire logic [obb_sat_pkg::HALF_W-1:0]   i_a_half_lengths,
    input  wire logic [obb_sat_pkg::AXIS_W-1:0]   i_a_axis_0,
    input  wire logic [obb_sat_pkg::AXIS_W-1:0]   i_a_axis_1,
    input  wire logic [obb_sat_pkg::AXIS_W-1:0]   i_a_axis_2,
    input  wire logic [obb_sat_pkg::CENTER_W-1:0] i_b_center,
    input  wire logic [obb_sat_pkg::HALF_W-1:0]   i_b_half_lengths,
    input  wire logic [obb_sat_pkg::AXIS_W-1:0]   i_b_axis_0,
    input  wire logic [obb_sat_pkg::AXIS_W-1:0]   i_b_axis_1,
    input  wire logic [obb_sat_pkg::AXIS_W-1:0]   i_b_axis_2,
    output logic o_valid,
    input  wire logic i_ready,
    output logic o_overlap
);
    import obb_sat_pkg::*;

    localparam int F   = AXIS_FRAC_BITS;
    localparam int AXW = F + 2;
    localparam int RW  = 2 * AXW + 2;
    localparam int ARW = RW - 1;
    localparam int TW  = POS_WIDTH + 1 + AXW + 2;
    localparam int CW  = TW + RW + F + 4;

    logic                         en;
    logic [NAX*POS_WIDTH-1:0]     ac_x, bc_x;
    logic [NAX*HALF_WIDTH-1:0]    ah_x, bh_x;
    logic [NAX*AXW-1:0]           aa_x [NAX];
    logic [NAX*AXW-1:0]           ba_x [NAX];
    logic signed [POS_WIDTH-1:0]  pa [NAX];
    logic signed [POS_WIDTH-1:0]  pb [NAX];
    logic [HALF_WIDTH-1:0]        ha [NAX];
    logic [HALF_WIDTH-1:0]        hb [NAX];
    logic signed [AXW-1:0]        ax [NAX][NAX];
    logic signed [AXW-1:0]        bx [NAX][NAX];
    logic                         rot_valid;
    logic signed [RW-1:0]         rot_r  [NAX][NAX];
    logic [ARW-1:0]               rot_ar [NAX][NAX];
    logic signed [TW-1:0]         rot_t  [NAX];
    logic [HALF_WIDTH-1:0]        rot_ha [NAX];
    logic [HALF_WIDTH-1:0]        rot_hb [NAX];
    logic                         proj_valid;
    logic signed [CW-1:0]         proj_p [NTEST];
    logic signed [CW-1:0]         proj_r [NTEST];

    // pipeline advances unless a finished result is held
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // unpack fields; bits above the packed components are dropped,
    // components past the field top read as zero
    assign ac_x     = (NAX*POS_WIDTH)'(i_a_center);
    assign bc_x     = (NAX*POS_WIDTH)'(i_b_center);
    assign ah_x     = (NAX*HALF_WIDTH)'(i_a_half_lengths);
    assign bh_x     = (NAX*HALF_WIDTH)'(i_b_half_lengths);
    assign aa_x[0]  = (NAX*AXW)'(i_a_axis_0);
    assign aa_x[1]  = (NAX*AXW)'(i_a_axis_1);
    assign aa_x[2]  = (NAX*AXW)'(i_a_axis_2);
    assign ba_x[0]  = (NAX*AXW)'(i_b_axis_0);
    assign ba_x[1]  = (NAX*AXW)'(i_b_axis_1);
    assign ba_x[2]  = (NAX*AXW)'(i_b_axis_2);

    always_comb begin
        for (int k = 0; k < NAX; k++) begin
            pa[k] = $signed(ac_x[k*POS_WIDTH +: POS_WIDTH]);
            pb[k] = $signed(bc_x[k*POS_WIDTH +: POS_WIDTH]);
            ha[k] = ah_x[k*HALF_WIDTH +: HALF_WIDTH];
            hb[k] = bh_x[k*HALF_WIDTH +: HALF_WIDTH];
            for (int i = 0; i < NAX; i++) begin
                ax[i][k] = $signed(aa_x[i][k*AXW +: AXW]);
                bx[i][k] = $signed(ba_x[i][k*AXW +: AXW]);
            end
        end
    end

    // rotation matrix and offset
    obb_sat_rot #(
        .AXIS_FRAC_BITS(AXIS_FRAC_BITS),
        .POS_WIDTH     (POS_WIDTH),
        .HALF_WIDTH    (HALF_WIDTH)
    ) u_rot (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(i_valid),
        .i_pa   (pa),
        .i_pb   (pb),
        .i_ha   (ha),
        .i_hb   (hb),
        .i_ax   (ax),
        .i_bx   (bx),
        .o_valid(rot_valid),
        .o_r    (rot_r),
        .o_ar   (rot_ar),
        .o_t    (rot_t),
        .o_ha   (rot_ha),
        .o_hb   (rot_hb)
    );

    // per-axis projections and radii
    obb_sat_proj #(
        .AXIS_FRAC_BITS(AXIS_FRAC_BITS),
        .POS_WIDTH     (POS_WIDTH),
        .HALF_WIDTH    (HALF_WIDTH)
    ) u_proj (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (en),
        .i_valid(rot_valid),
        .i_r    (rot_r),
        .i_ar   (rot_ar),
        .i_t    (rot_t),
        .i_ha   (rot_ha),
        .i_hb   (rot_hb),
        .o_valid(proj_valid),
        .o_proj (proj_p),
        .o_rhs  (proj_r)
    );

    // compare and reduce
    obb_sat_cmp #(
        .CW(CW)
    ) u_cmp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (proj_valid),
        .i_proj   (proj_p),
        .i_rhs    (proj_r),
        .o_valid  (o_valid),
        .o_overlap(o_overlap)
    );

`ifndef SYNTHESIS
    // a held result freezes every stage valid
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(rot_valid) && $stable(proj_valid) && $stable(o_valid))
        else $error("pipeline moved during stall");

    // reset empties the pipeline
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !rot_valid && !proj_valid && !o_valid)
        else $error("stage valid survived reset");

    // an empty output never refuses input
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input refused with empty output");
`endif
endmodule
`default_nettype wire
